/* hdl/linear_rgb_to_oklab_assert.svh */
// ----------------------------------------------------------------------------
// linear_rgb_to_oklab assertion macros
// Shared concurrent check forms, clocked on i_clk and idle while in reset.
// ----------------------------------------------------------------------------
`ifndef LINEAR_RGB_TO_OKLAB_ASSERT_SVH
`define LINEAR_RGB_TO_OKLAB_ASSERT_SVH

// condition must hold at every clock edge out of reset
`define OKLAB_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// antecedent at one edge implies the consequent at the next edge
`define OKLAB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/oklab_pkg.sv */
// ----------------------------------------------------------------------------
// oklab_pkg
// Widths, coefficient tables, cube root seed table and shared types for the
// linear RGB to OKLab pipeline.
// ----------------------------------------------------------------------------
package oklab_pkg;

    // fixed-point configuration
    localparam int COEF_FRAC_BITS = 18;
    localparam int ROOT_STEPS     = 2;

    // field and datapath widths
    localparam int CH_W      = 16;
    localparam int CF_W      = COEF_FRAC_BITS;
    localparam int CB_W      = COEF_FRAC_BITS + 3;
    localparam int LMS_W     = 32;
    localparam int SEED_W    = 21;
    localparam int SEED_IDX  = 6;
    localparam int Y_W       = 22;
    localparam int E_W       = 4;
    localparam int Q_W       = 23;
    localparam int DIV_SH    = 28;
    localparam int N_W       = LMS_W + DIV_SH;
    localparam int D_W       = 2 * Y_W;
    localparam int SUB_W     = D_W + Q_W + 1;
    localparam int V_W       = 25;
    localparam int RECIP_W   = 24;
    localparam int RECIP_SH  = 25;
    localparam logic [RECIP_W-1:0] RECIP_3 = 24'hAAAAAB;
    localparam int ROOT_W    = Y_W;
    localparam int FWD_ACC_W = CH_W + CF_W + 2;
    localparam int WIDE_W    = FWD_ACC_W + CH_W;
    localparam int OUT_ACC_W = CB_W + ROOT_W + 1 + 2;

    // pipeline depths
    localparam int NEWTON_LAT = Q_W + 2;
    localparam int CBRT_LAT   = 3 + ROOT_STEPS * NEWTON_LAT;

    // pixel payloads
    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] alpha_in;
    } t_rgba_in;

    typedef struct packed {
        logic        [15:0] lightness;
        logic signed [15:0] green_red_axis;
        logic signed [15:0] blue_yellow_axis;
        logic        [15:0] alpha_out;
    } t_oklab_out;

    // cube root working set carried between newton steps
    typedef struct packed {
        logic [Y_W-1:0]   y;
        logic [LMS_W-1:0] xn;
        logic [E_W-1:0]   e;
        logic             zero;
    } t_newton;

    typedef logic [SEED_W-1:0] t_seed_rom [2**SEED_IDX];

    // coefficient quantization, round half away from zero
    function automatic longint f_qcoef(longint c9);
        longint unsigned mag;
        longint unsigned q;
        mag = (c9 < 0) ? longint'(-c9) : longint'(c9);
        q   = (mag * (64'd1 << COEF_FRAC_BITS) + 64'd500000000) / 64'd1000000000;
        return (c9 < 0) ? -longint'(q) : longint'(q);
    endfunction

    // seed table: floor cube root of bucket midpoints
    function automatic t_seed_rom f_seed_rom();
        t_seed_rom       rom;
        longint unsigned n;
        longint unsigned y;
        longint unsigned t;
        for (int i = 0; i < 2**SEED_IDX; i++) begin
            n = ((2 * longint'(i)) + 1) << 53;
            y = 0;
            for (int b = SEED_W - 1; b >= 0; b--) begin
                t = y | (64'd1 << b);
                if (t * t * t <= n) begin
                    y = t;
                end
            end
            rom[i] = SEED_W'(y);
        end
        return rom;
    endfunction

    localparam t_seed_rom SEED_ROM = f_seed_rom();

    // linear RGB to LMS
    localparam logic [CF_W-1:0] FWD_COEF [9] = '{
        CF_W'(f_qcoef(412221471)), CF_W'(f_qcoef(536332536)), CF_W'(f_qcoef(51445993)),
        CF_W'(f_qcoef(211903498)), CF_W'(f_qcoef(680699545)), CF_W'(f_qcoef(107396957)),
        CF_W'(f_qcoef(88302462)),  CF_W'(f_qcoef(281718838)), CF_W'(f_qcoef(629978701))
    };

    // cube-rooted LMS to OKLab
    localparam logic signed [CB_W-1:0] BACK_COEF [9] = '{
        CB_W'(f_qcoef(210454255)),  CB_W'(f_qcoef(793617785)),
        CB_W'(f_qcoef(-4072047)),
        CB_W'(f_qcoef(1977998495)), CB_W'(f_qcoef(-64'sd2428592205)),
        CB_W'(f_qcoef(450593710)),
        CB_W'(f_qcoef(25904037)),   CB_W'(f_qcoef(782771766)),
        CB_W'(f_qcoef(-808675766))
    };

endpackage

/* hdl/linear_rgb_to_oklab.sv */
// Throughput: one request per clock; the whole pipeline advances together and
// holds in place while a finished result waits on i_ready.
// Depth is set by the per-bit restoring divider inside each newton step.
// Reset (synchronous, active low) clears all valid bits and sets default
// alpha to 65535; no clearing pass is needed.
// ----------------------------------------------------------------------------
// linear_rgb_to_oklab
// Linear RGB with alpha to OKLab: LMS matrix, three cube root pipelines and
// the output matrix, plus the default alpha register.
// ----------------------------------------------------------------------------
`include "linear_rgb_to_oklab_assert.svh"

module linear_rgb_to_oklab import oklab_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_rgba_in   i_pixel,
    output logic       o_valid,
    input  logic       i_ready,
    output t_oklab_out o_pixel,
    input  logic       i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data
);

    localparam logic [ROOT_W-1:0] ROOT_MAX = ROOT_W'((1 << 20) + (1 << 14));

    logic                   w_en;
    logic [15:0]            r_default_alpha;
    logic                   w_lms_vld;
    logic [2:0][LMS_W-1:0]  w_lms;
    logic [15:0]            w_lms_alpha;
    logic [2:0][ROOT_W-1:0] w_root;
    logic [CBRT_LAT-1:0]    r_dly_vld;
    logic [15:0]            r_dly_alpha [CBRT_LAT];

    // pipeline advances unless the output register holds an untaken result
    assign w_en    = ~o_valid | i_ready;
    assign o_ready = w_en;

    // default alpha register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_alpha <= 16'hFFFF;
        end else if (i_cfg_wr_en) begin
            r_default_alpha <= i_cfg_wr_data;
        end
    end

    // rgb to lms
    oklab_lms u_lms (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (w_en),
        .i_valid         (i_valid),
        .i_pixel         (i_pixel),
        .i_default_alpha (r_default_alpha),
        .o_valid         (w_lms_vld),
        .o_lms           (w_lms),
        .o_alpha         (w_lms_alpha)
    );

    // one cube root pipeline per lms channel
    for (genvar c = 0; c < 3; c++) begin : g_cbrt
        oklab_cbrt u_cbrt (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_lms  (w_lms[c]),
            .o_root (w_root[c])
        );
    end

    // valid and alpha ride alongside the cube root pipelines
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dly_vld <= '0;
        end else if (w_en) begin
            r_dly_vld <= {r_dly_vld[CBRT_LAT-2:0], w_lms_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dly_alpha[0] <= w_lms_alpha;
            for (int k = 1; k < CBRT_LAT; k++) begin
                r_dly_alpha[k] <= r_dly_alpha[k-1];
            end
        end
    end

    // roots to oklab
    oklab_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_dly_vld[CBRT_LAT-1]),
        .i_root  (w_root),
        .i_alpha (r_dly_alpha[CBRT_LAT-1]),
        .o_valid (o_valid),
        .o_pixel (o_pixel)
    );

    // checks
    `OKLAB_ASSERT_NEXT(a_stall_freezes, (o_valid && !i_ready), $stable(r_dly_vld), "pipeline moved during output stall")
    `OKLAB_ASSERT_ALWAYS(a_alpha_nonzero, (!o_valid || r_default_alpha == '0 || o_pixel.alpha_out != '0), "zero alpha given out with nonzero default")
    `OKLAB_ASSERT_ALWAYS(a_root_range, (!r_dly_vld[CBRT_LAT-1] || (w_root[0] <= ROOT_MAX && w_root[1] <= ROOT_MAX && w_root[2] <= ROOT_MAX)), "cube root out of range")

endmodule

/* hdl/oklab_lms.sv */
// ----------------------------------------------------------------------------
// oklab_lms
// First matrix: linear RGB to LMS in Q0.32, rounded and clamped. Also
// resolves the output alpha. Two register stages.
// ----------------------------------------------------------------------------
module oklab_lms import oklab_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  t_rgba_in                   i_pixel,
    input  logic [15:0]                i_default_alpha,
    output logic                       o_valid,
    output logic [2:0][LMS_W-1:0]      o_lms,
    output logic [15:0]                o_alpha
);

    logic [CH_W-1:0]      w_ch [3];
    logic [CH_W+CF_W-1:0] r_prod [9];
    logic                 r_a_vld;
    logic [15:0]          r_a_alpha;
    logic [LMS_W-1:0]     w_lms [3];
    logic                 r_b_vld;
    logic [2:0][LMS_W-1:0] r_lms;
    logic [15:0]          r_b_alpha;

    assign w_ch[0] = i_pixel.red;
    assign w_ch[1] = i_pixel.green;
    assign w_ch[2] = i_pixel.blue;

    // stage a valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_valid;
        end
    end

    // stage a products and alpha select
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_prod[r*3+c] <= (CH_W+CF_W)'(w_ch[c]) * (CH_W+CF_W)'(FWD_COEF[r*3+c]);
                end
            end
            r_a_alpha <= (i_pixel.alpha_in != '0) ? i_pixel.alpha_in : i_default_alpha;
        end
    end

    // row sums, rescale to q0.32, clamp
    for (genvar r = 0; r < 3; r++) begin : g_row
        logic [FWD_ACC_W-1:0] w_acc;
        logic [WIDE_W-1:0]    w_wide;

        assign w_acc = FWD_ACC_W'(r_prod[r*3]) + FWD_ACC_W'(r_prod[r*3+1])
                     + FWD_ACC_W'(r_prod[r*3+2]);

        if (COEF_FRAC_BITS > CH_W) begin : g_rnd
            assign w_wide = WIDE_W'((WIDE_W'(w_acc)
                          + (WIDE_W'(1) << (COEF_FRAC_BITS - CH_W - 1)))
                          >> (COEF_FRAC_BITS - CH_W));
        end else begin : g_shl
            assign w_wide = WIDE_W'(w_acc) << (CH_W - COEF_FRAC_BITS);
        end

        assign w_lms[r] = (|w_wide[WIDE_W-1:LMS_W]) ? '1 : w_wide[LMS_W-1:0];
    end

    // stage b valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (i_en) begin
            r_b_vld <= r_a_vld;
        end
    end

    // stage b payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                r_lms[r] <= w_lms[r];
            end
            r_b_alpha <= r_a_alpha;
        end
    end

    assign o_valid = r_b_vld;
    assign o_lms   = r_lms;
    assign o_alpha = r_b_alpha;

endmodule

/* hdl/oklab_newton.sv */
// ----------------------------------------------------------------------------
// oklab_newton
// One newton step of the cube root: square, restoring divide one quotient
// bit per stage, then (2y + q + 1) / 3 by reciprocal multiply.
// ----------------------------------------------------------------------------
module oklab_newton import oklab_pkg::*; (
    input  logic    i_clk,
    input  logic    i_en,
    input  t_newton i_d,
    output t_newton o_d
);

    logic [Y_W-1:0]   w_yf;
    logic [D_W-1:0]   r_sq;
    t_newton          r_n0;
    logic [N_W-1:0]   r_rem [Q_W];
    logic [Q_W-1:0]   r_quo [Q_W];
    logic [D_W-1:0]   r_dv  [Q_W];
    t_newton          r_st  [Q_W];
    logic [N_W-1:0]   w_rem_in [Q_W];
    logic [Q_W-1:0]   w_quo_in [Q_W];
    logic [D_W-1:0]   w_dv_in  [Q_W];
    t_newton          w_st_in  [Q_W];
    logic [V_W-1:0]   w_v;
    logic [V_W+RECIP_W-1:0] r_prod;
    t_newton          r_n1;

    // square the estimate, a zero estimate is forced to one
    assign w_yf = (i_d.y == '0) ? Y_W'(1) : i_d.y;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq <= D_W'(w_yf) * D_W'(w_yf);
            r_n0 <= '{y: w_yf, xn: i_d.xn, e: i_d.e, zero: i_d.zero};
        end
    end

    // divider stage inputs
    assign w_rem_in[0] = {r_n0.xn, DIV_SH'(0)};
    assign w_quo_in[0] = '0;
    assign w_dv_in[0]  = r_sq;
    assign w_st_in[0]  = r_n0;

    for (genvar k = 1; k < Q_W; k++) begin : g_link
        assign w_rem_in[k] = r_rem[k-1];
        assign w_quo_in[k] = r_quo[k-1];
        assign w_dv_in[k]  = r_dv[k-1];
        assign w_st_in[k]  = r_st[k-1];
    end

    // restoring divide, most significant quotient bit first
    for (genvar k = 0; k < Q_W; k++) begin : g_div
        localparam int BIT = Q_W - 1 - k;
        logic [SUB_W-1:0] w_dsh;
        logic [SUB_W-1:0] w_diff;
        logic             w_take;

        assign w_dsh  = SUB_W'(w_dv_in[k]) << BIT;
        assign w_diff = SUB_W'(w_rem_in[k]) - w_dsh;
        assign w_take = ~w_diff[SUB_W-1];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_take ? w_diff[N_W-1:0] : w_rem_in[k];
                r_quo[k] <= w_quo_in[k] | (Q_W'(w_take) << BIT);
                r_dv[k]  <= w_dv_in[k];
                r_st[k]  <= w_st_in[k];
            end
        end
    end

    // (2y + q + 1) times the reciprocal of three
    assign w_v = V_W'({r_st[Q_W-1].y, 1'b0}) + V_W'(r_quo[Q_W-1]) + V_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= (V_W+RECIP_W)'(w_v) * (V_W+RECIP_W)'(RECIP_3);
            r_n1   <= r_st[Q_W-1];
        end
    end

    // new estimate
    always_comb begin
        o_d   = r_n1;
        o_d.y = Y_W'(r_prod >> RECIP_SH);
    end

endmodule

/* hdl/oklab_cbrt.sv */
// ----------------------------------------------------------------------------
// oklab_cbrt
// Cube root of one Q0.32 LMS value into Q0.20: normalize by multiples of
// three bits, seed from a table, newton steps, then scale back with rounding.
// ----------------------------------------------------------------------------
module oklab_cbrt import oklab_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [LMS_W-1:0]  i_lms,
    output logic [ROOT_W-1:0] o_root
);

    logic [LMS_W-1:0] w_x1;
    logic [LMS_W-1:0] w_x2;
    logic [LMS_W-1:0] w_x3;
    logic [LMS_W-1:0] w_x4;
    logic [E_W-1:0]   w_e;
    logic [LMS_W-1:0] r_xn0;
    logic [E_W-1:0]   r_e0;
    logic             r_zero0;
    t_newton          r_s1;
    t_newton          w_chain [ROOT_STEPS+1];
    t_newton          w_fin;
    logic [Y_W:0]     w_sum;
    logic [ROOT_W-1:0] r_root;

    // normalize: shift by 24, 12, 6, 3 while the top bits stay zero
    assign w_e[3] = (i_lms[31:8] == '0);
    assign w_x1   = w_e[3] ? (i_lms << 24) : i_lms;
    assign w_e[2] = (w_x1[31:20] == '0);
    assign w_x2   = w_e[2] ? (w_x1 << 12) : w_x1;
    assign w_e[1] = (w_x2[31:26] == '0);
    assign w_x3   = w_e[1] ? (w_x2 << 6) : w_x2;
    assign w_e[0] = (w_x3[31:29] == '0);
    assign w_x4   = w_e[0] ? (w_x3 << 3) : w_x3;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xn0   <= w_x4;
            r_e0    <= w_e;
            r_zero0 <= (i_lms == '0);
        end
    end

    // seed lookup
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1.y    <= Y_W'(SEED_ROM[r_xn0[LMS_W-1 -: SEED_IDX]]);
            r_s1.xn   <= r_xn0;
            r_s1.e    <= r_e0;
            r_s1.zero <= r_zero0;
        end
    end

    assign w_chain[0] = r_s1;

    for (genvar s = 0; s < ROOT_STEPS; s++) begin : g_step
        oklab_newton u_newton (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_d   (w_chain[s]),
            .o_d   (w_chain[s+1])
        );
    end

    // undo normalization with round half up
    assign w_fin = w_chain[ROOT_STEPS];
    assign w_sum = (Y_W+1)'(w_fin.y) + (((Y_W+1)'(1) << w_fin.e) >> 1);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_root <= w_fin.zero ? '0 : ROOT_W'(w_sum >> w_fin.e);
        end
    end

    assign o_root = r_root;

endmodule

/* hdl/oklab_out.sv */
// ----------------------------------------------------------------------------
// oklab_out
// Second matrix: cube roots to OKLab L, a, b with rounding and saturation.
// The second stage is the output register of the block.
// ----------------------------------------------------------------------------
module oklab_out import oklab_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [2:0][ROOT_W-1:0] i_root,
    input  logic [15:0]            i_alpha,
    output logic                   o_valid,
    output t_oklab_out             o_pixel
);

    localparam logic signed [OUT_ACC_W-1:0] L_MAX  = 65535;
    localparam logic signed [OUT_ACC_W-1:0] AB_MAX = 32767;
    localparam logic signed [OUT_ACC_W-1:0] AB_MIN = -32768;

    logic signed [CB_W+ROOT_W:0] r_prod [9];
    logic                        r_a_vld;
    logic [15:0]                 r_a_alpha;
    logic [15:0]                 w_res [3];
    logic                        r_b_vld;
    t_oklab_out                  r_pix;

    // stage a valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_valid;
        end
    end

    // stage a products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_prod[r*3+c] <= (CB_W+ROOT_W+1)'(BACK_COEF[r*3+c])
                                   * $signed({1'b0, i_root[c]});
                end
            end
            r_a_alpha <= i_alpha;
        end
    end

    // row sums, round half up, saturate
    for (genvar r = 0; r < 3; r++) begin : g_row
        localparam int SH = (r == 0) ? COEF_FRAC_BITS + 4 : COEF_FRAC_BITS + 5;
        logic signed [OUT_ACC_W-1:0] w_acc;
        logic signed [OUT_ACC_W-1:0] w_t;

        assign w_acc = OUT_ACC_W'(r_prod[r*3]) + OUT_ACC_W'(r_prod[r*3+1])
                     + OUT_ACC_W'(r_prod[r*3+2]);
        assign w_t   = (w_acc + (OUT_ACC_W'(1) << (SH - 1))) >>> SH;

        if (r == 0) begin : g_unsigned
            assign w_res[r] = (w_t < 0) ? 16'd0 : ((w_t > L_MAX) ? 16'hFFFF : w_t[15:0]);
        end else begin : g_signed
            assign w_res[r] = (w_t < AB_MIN) ? 16'h8000
                            : ((w_t > AB_MAX) ? 16'h7FFF : w_t[15:0]);
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (i_en) begin
            r_b_vld <= r_a_vld;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pix.lightness        <= w_res[0];
            r_pix.green_red_axis   <= w_res[1];
            r_pix.blue_yellow_axis <= w_res[2];
            r_pix.alpha_out        <= r_a_alpha;
        end
    end

    assign o_valid = r_b_vld;
    assign o_pixel = r_pix;

endmodule
